FILE: rtl/matrix_multiply_6x6_defines.svh
// Assertion helpers shared by the RTL files.
// Both forms are clocked on clk and switched off while arst_n is low.
`ifndef MATRIX_MULTIPLY_6X6_DEFINES_SVH
`define MATRIX_MULTIPLY_6X6_DEFINES_SVH

// Same-cycle property: prop must hold at every clock edge.
`define MMUL6_ASSERT(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (prop)) else $error(msg);

// Next-cycle implication: when pre holds, post must hold at the following edge.
`define MMUL6_ASSERT_NEXT(lbl, pre, post, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (pre) |=> (post)) else $error(msg);

`endif

FILE: rtl/mmul6_pkg.sv
package mmul6_pkg;

	// Field widths of the channels
	localparam int IDX_W = 3;
	localparam int VAL_W = 32;

	// Action codes of a command item
	localparam logic [1:0] ACT_LOAD_LEFT  = 2'd0;
	localparam logic [1:0] ACT_LOAD_RIGHT = 2'd1;
	localparam logic [1:0] ACT_START      = 2'd2;

	// Clamp values of a Q16.16 result
	localparam logic [VAL_W-1:0] SAT_POS = 32'h7FFF_FFFF;
	localparam logic [VAL_W-1:0] SAT_NEG = 32'h8000_0000;

	// Sequencer states
	typedef enum logic [2:0] {
		ST_IDLE   = 3'b001,
		ST_RUN    = 3'b010,
		ST_FINISH = 3'b100
	} state_t;

endpackage

FILE: rtl/mmul6_ifs.sv
// Command channel: element loads and start items
interface mmul6_cmd_if;
	logic                              valid;
	logic                              ready;
	logic [1:0]                        action;
	logic [mmul6_pkg::IDX_W-1:0]       row_index;
	logic [mmul6_pkg::IDX_W-1:0]       col_index;
	logic signed [mmul6_pkg::VAL_W-1:0] element_value;

	modport source (output valid, action, row_index, col_index, element_value, input ready);
	modport sink   (input valid, action, row_index, col_index, element_value, output ready);
endinterface

// Result channel: one product element per item
interface mmul6_res_if;
	logic                              valid;
	logic                              ready;
	logic [mmul6_pkg::IDX_W-1:0]       out_row;
	logic [mmul6_pkg::IDX_W-1:0]       out_col;
	logic signed [mmul6_pkg::VAL_W-1:0] product_value;
	logic                              saturated;
	logic                              last;

	modport source (output valid, out_row, out_col, product_value, saturated, last, input ready);
	modport sink   (input valid, out_row, out_col, product_value, saturated, last, output ready);
endinterface

FILE: rtl/matrix_multiply_6x6.sv
// Fixed-point square matrix multiply C = A*B, DIM x DIM, signed Q16.16.
// cmd channel (valid/ready): action LOAD_LEFT / LOAD_RIGHT writes one element of
//   A or B at (row_index, col_index); indexes >= DIM and action 3 are dropped.
//   START runs the product; cmd.ready stays low until the last element has
//   been placed in the output register.
// res channel (valid/ready): DIM*DIM items, row by row, last set on the final one.
//   Each sum is exact, shifted right arithmetically by FRAC_BITS and clamped to
//   32 bits with saturated raised on a clamp.
// Structure: one multiplier and one accumulator are shared. Each element reads
//   and multiplies DIM operand pairs, then waits for the read and multiply
//   registers to drain before its sum is loaded into the output register; the
//   next element starts only after that load.
// A stalled receiver holds the output register and the sequencer waits for it
//   before loading the next element; nothing is dropped.
// Reset (arst_n low) returns the sequencer to idle and clears the output valid.
//   Matrix contents are not cleared: elements must be loaded before use.
`include "matrix_multiply_6x6_defines.svh"

module matrix_multiply_6x6 #(
	parameter int DIM       = 6,
	parameter int FRAC_BITS = 16
) (
	input  logic               clk,
	input  logic               arst_n,
	mmul6_cmd_if.sink          cmd,
	mmul6_res_if.source        res
);

	localparam int CELLS = DIM * DIM;
	localparam int AW    = $clog2(CELLS);
	localparam int IW    = $clog2(DIM);
	localparam int ACC_W = 65 + $clog2(DIM);
	localparam int VW    = mmul6_pkg::VAL_W;
	localparam int XW    = mmul6_pkg::IDX_W;

	mmul6_pkg::state_t state_q;

	logic [IW-1:0] r_q, c_q, k_q;
	logic          val_s1, val_s2;

	logic [VW-1:0]        left_mem  [CELLS];
	logic [VW-1:0]        right_mem [CELLS];
	logic signed [VW-1:0] a_s1, b_s1;
	logic signed [2*VW-1:0] prod_s2;
	logic signed [ACC_W-1:0] acc_q;

	logic          out_valid_q;
	logic [IW-1:0] out_row_q, out_col_q;
	logic [VW-1:0] out_val_q;
	logic          out_sat_q;
	logic          out_last_q;

	logic          cmd_fire;
	logic          in_range;
	logic [AW-1:0] wr_addr, rd_a_addr, rd_b_addr;
	logic          last_k, last_c, last_elem;
	logic          emit;
	logic signed [ACC_W-1:0] shifted;
	logic          fits;
	logic [VW-1:0] final_val;

	// Command handshake
	assign cmd.ready = (state_q == mmul6_pkg::ST_IDLE);
	assign cmd_fire  = cmd.valid && cmd.ready;
	assign in_range  = ({1'b0, cmd.row_index} < (XW+1)'(DIM)) &&
	                   ({1'b0, cmd.col_index} < (XW+1)'(DIM));
	assign wr_addr   = AW'(cmd.row_index) * AW'(DIM) + AW'(cmd.col_index);

	// Read addresses: A walks row r, B walks column c
	assign rd_a_addr = AW'(r_q) * AW'(DIM) + AW'(k_q);
	assign rd_b_addr = AW'(k_q) * AW'(DIM) + AW'(c_q);

	assign last_k    = (k_q == IW'(DIM - 1));
	assign last_c    = (c_q == IW'(DIM - 1));
	assign last_elem = last_c && (r_q == IW'(DIM - 1));

	// Element done and output register free
	assign emit = (state_q == mmul6_pkg::ST_FINISH) && !val_s1 && !val_s2 &&
	              (!out_valid_q || res.ready);

	// Matrix storage, one write and one registered read per cycle each
	always_ff @(posedge clk) begin
		if (cmd_fire && in_range && cmd.action == mmul6_pkg::ACT_LOAD_LEFT) begin
			left_mem[wr_addr] <= cmd.element_value;
		end
		if (cmd_fire && in_range && cmd.action == mmul6_pkg::ACT_LOAD_RIGHT) begin
			right_mem[wr_addr] <= cmd.element_value;
		end
		a_s1 <= left_mem[rd_a_addr];
		b_s1 <= right_mem[rd_b_addr];
	end

	// Shared multiplier, registered
	always_ff @(posedge clk) begin
		prod_s2 <= a_s1 * b_s1;
	end

	// Pipeline valid bits
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			val_s1 <= 1'b0;
			val_s2 <= 1'b0;
		end else begin
			val_s1 <= (state_q == mmul6_pkg::ST_RUN);
			val_s2 <= val_s1;
		end
	end

	// Accumulator: cleared at start of each element
	always_ff @(posedge clk) begin
		if ((cmd_fire && cmd.action == mmul6_pkg::ACT_START) || emit) begin
			acc_q <= '0;
		end else if (val_s2) begin
			acc_q <= acc_q + ACC_W'(prod_s2);
		end
	end

	// Scale and clamp
	assign shifted   = acc_q >>> FRAC_BITS;
	assign fits      = (&shifted[ACC_W-1:VW-1]) || !(|shifted[ACC_W-1:VW-1]);
	assign final_val = fits ? shifted[VW-1:0] :
	                   (shifted[ACC_W-1] ? mmul6_pkg::SAT_NEG : mmul6_pkg::SAT_POS);

	// Sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= mmul6_pkg::ST_IDLE;
			r_q     <= '0;
			c_q     <= '0;
			k_q     <= '0;
		end else begin
			case (state_q)
				mmul6_pkg::ST_IDLE: begin
					if (cmd_fire && cmd.action == mmul6_pkg::ACT_START) begin
						state_q <= mmul6_pkg::ST_RUN;
						r_q     <= '0;
						c_q     <= '0;
						k_q     <= '0;
					end
				end
				mmul6_pkg::ST_RUN: begin
					if (last_k) begin
						k_q     <= '0;
						state_q <= mmul6_pkg::ST_FINISH;
					end else begin
						k_q <= k_q + 1'b1;
					end
				end
				mmul6_pkg::ST_FINISH: begin
					if (emit) begin
						if (last_elem) begin
							state_q <= mmul6_pkg::ST_IDLE;
							r_q     <= '0;
							c_q     <= '0;
						end else begin
							state_q <= mmul6_pkg::ST_RUN;
							if (last_c) begin
								c_q <= '0;
								r_q <= r_q + 1'b1;
							end else begin
								c_q <= c_q + 1'b1;
							end
						end
					end
				end
				default: begin
					state_q <= mmul6_pkg::ST_IDLE;
				end
			endcase
		end
	end

	// Output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (emit) begin
			out_valid_q <= 1'b1;
		end else if (res.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (emit) begin
			out_row_q  <= r_q;
			out_col_q  <= c_q;
			out_val_q  <= final_val;
			out_sat_q  <= !fits;
			out_last_q <= last_elem;
		end
	end

	assign res.valid         = out_valid_q;
	assign res.out_row       = XW'(out_row_q);
	assign res.out_col       = XW'(out_col_q);
	assign res.product_value = out_val_q;
	assign res.saturated     = out_sat_q;
	assign res.last          = out_last_q;

	// Checks
	`MMUL6_ASSERT(a_idle_pipe_empty, state_q != mmul6_pkg::ST_IDLE || (!val_s1 && !val_s2), "pipeline busy while idle")
	`MMUL6_ASSERT(a_emit_drained, !emit || (!val_s1 && !val_s2 && k_q == '0), "element emitted before sum complete")
	`MMUL6_ASSERT_NEXT(a_start_clears, cmd_fire && cmd.action == mmul6_pkg::ACT_START, state_q == mmul6_pkg::ST_RUN && acc_q == '0 && k_q == '0, "start did not clear accumulator")
	`MMUL6_ASSERT_NEXT(a_last_to_idle, emit && last_elem, state_q == mmul6_pkg::ST_IDLE && out_valid_q && out_last_q, "last element did not end the product")

endmodule
